FILE: hw/rtl/mhf_pkg.sv
// Shared constants, types and CRC helper functions for the multicast hash filter.
`timescale 1ns / 1ps
`default_nettype none

package mhf_pkg;

    localparam int HASH_BITS_DEF = 9;
    localparam int HASH_BITS_MAX = 12;
    localparam int MAC_W         = 48;
    localparam int CMD_W         = 2;
    localparam int OUT_IDX_W     = 9;
    localparam int OUT_TDATA_W   = 16;
    localparam int CFG_IDX_W     = 1;

    // The table is held as words of 2**ROW_LSB_W bits.
    localparam int ROW_LSB_W     = 5;
    localparam int WORD_W        = 1 << ROW_LSB_W;
    localparam int ROW_MAX_W     = HASH_BITS_MAX - ROW_LSB_W;

    localparam logic [CMD_W-1:0] CMD_REBUILD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ALL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_EN  = 1'd1;

    localparam logic [31:0]      CRC_POLY  = 32'hEDB88320;
    localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef logic [31:0][MAC_W-1:0] t_mask_mat;

    typedef struct packed {
        logic                 wr_en;
        logic [ROW_MAX_W-1:0] row;
        logic [WORD_W-1:0]    data;
        logic                 clear_all;
        logic                 base;
    } t_tbl_op;

    // Bit-serial reflected CRC-32 over the address, used at elaboration only.
    function automatic logic [31:0] crc_reg(input logic [MAC_W-1:0] mac);
        logic [31:0] crc;
        crc = '1;
        for (int i = 0; i < MAC_W; i++) begin
            if (crc[0] ^ mac[i]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    // The CRC is affine in the address: each CRC bit is a constant XOR a parity
    // of address bits. Row j of the result selects the address bits of CRC bit j.
    function automatic t_mask_mat hash_masks();
        t_mask_mat   m;
        logic [31:0] base;
        logic [31:0] col;
        m    = '0;
        base = crc_reg('0);
        for (int i = 0; i < MAC_W; i++) begin
            col = crc_reg(MAC_W'(1) << i) ^ base;
            for (int j = 0; j < 32; j++) begin
                m[j][i] = col[j];
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mhf_table.sv
// Hash table memory with per-row valid bits and a rebuild base value.
`timescale 1ns / 1ps
`default_nettype none

module mhf_table import mhf_pkg::*; #(
    parameter int HASH_BITS = HASH_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_rd_en,
    input  wire logic [HASH_BITS-ROW_LSB_W-1:0]  i_rd_row,
    output logic      [WORD_W-1:0]               o_rd_word,
    input  wire t_tbl_op                         i_op
);

    localparam int ROW_W = HASH_BITS - ROW_LSB_W;
    localparam int DEPTH = 1 << ROW_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DEPTH-1:0]  n_valid;
    logic              r_base;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_valid;
    logic [ROW_W-1:0]  wr_row;

    assign wr_row = i_op.row[ROW_W-1:0];

    always_comb begin
        n_valid = r_valid;
        if (i_op.clear_all) begin
            n_valid = '0;
        end
        if (i_op.wr_en) begin
            n_valid[wr_row] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
        if (i_op.wr_en) begin
            r_mem[wr_row] <= i_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_base     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_op.clear_all) begin
                r_base <= i_op.base;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_row];
            end
        end
    end

    // A row not written since the last rebuild reads as the rebuild value.
    assign o_rd_word = r_rd_valid ? r_rd_data : {WORD_W{r_base}};

endmodule

`default_nettype wire

FILE: hw/rtl/multicast_hash_filter.sv
// Top level of the multicast hash filter: CRC hashing, command control and output stage.
//
// Items enter on the s_axis channel: tdata carries the 48-bit address and
// tuser the command (rebuild, add or test). Each item gives exactly one
// result on the m_axis channel with the address's hash index and the table
// bit at that index after the command. Two registers, fill_all and
// broadcast_enable, are written through the cfg channel; the user must
// write them only while no item is in flight, as the block itself does
// not enforce it. The cfg channel is always ready. The hash is a parallel
// XOR network over the address. An accepted item reads its table word
// at the accept edge; in the execute state, once the output register is
// free, the word is modified, written back and the result is loaded into
// the output register. No new item is taken while one is in the execute
// state. A rebuild clears all rows at once through per-row valid bits.
// Reset empties the table and leaves fill_all at 0 and broadcast_enable
// at 1. While the receiver stalls, the result waits in the output register
// and one more item can be taken and held until it drains.
`timescale 1ns / 1ps
`default_nettype none

module multicast_hash_filter import mhf_pkg::*; #(
    parameter int HASH_BITS = HASH_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [MAC_W-1:0]        s_axis_tdata,   // [47:0] mac
    input  wire logic [CMD_W-1:0]        s_axis_tuser,   // [1:0] cmd
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic      [OUT_TDATA_W-1:0]  m_axis_tdata,   // [8:0] hash_index, [9] hit
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic                    i_cfg_data
);

    localparam int ROW_W = HASH_BITS - ROW_LSB_W;

    localparam t_mask_mat   HASH_MASK  = hash_masks();
    localparam logic [31:0] HASH_INIT  = crc_reg('0);
    localparam logic [31:0] BCAST_CRC  = crc_reg(BCAST_MAC);
    localparam logic [HASH_BITS-1:0] BCAST_H = BCAST_CRC[HASH_BITS-1:0];

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 r_state;
    logic [CMD_W-1:0]     r_cmd;
    logic [HASH_BITS-1:0] r_hash;
    logic                 r_fill_all;
    logic                 r_bcast_en;
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_index;
    logic                 r_out_hit;

    logic [HASH_BITS-1:0] hash_now;
    logic                 accept;
    logic                 out_free;
    logic                 done;
    logic [WORD_W-1:0]    tbl_word;
    logic [WORD_W-1:0]    bit_mask;
    logic                 cur_bit;
    logic                 n_hit;
    t_tbl_op              tbl_op;

    always_comb begin
        for (int j = 0; j < HASH_BITS; j++) begin
            hash_now[j] = HASH_INIT[j] ^ (^(s_axis_tdata & HASH_MASK[j]));
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign done          = (r_state == ST_EXEC) && out_free;
    assign o_cfg_ready   = 1'b1;

    mhf_table #(
        .HASH_BITS (HASH_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_row  (hash_now[HASH_BITS-1:ROW_LSB_W]),
        .o_rd_word (tbl_word),
        .i_op      (tbl_op)
    );

    assign bit_mask = WORD_W'(1) << r_hash[ROW_LSB_W-1:0];
    assign cur_bit  = tbl_word[r_hash[ROW_LSB_W-1:0]];

    always_comb begin
        tbl_op = '0;
        n_hit  = cur_bit;
        case (r_cmd)
            CMD_REBUILD: begin
                tbl_op.clear_all = done;
                tbl_op.base      = r_fill_all;
                if (!r_fill_all && r_bcast_en) begin
                    tbl_op.wr_en = done;
                    tbl_op.row   = ROW_MAX_W'(BCAST_H[HASH_BITS-1:ROW_LSB_W]);
                    tbl_op.data  = WORD_W'(1) << BCAST_H[ROW_LSB_W-1:0];
                end
                n_hit = r_fill_all || (r_bcast_en && (r_hash == BCAST_H));
            end
            CMD_ADD: begin
                if (!r_fill_all) begin
                    tbl_op.wr_en = done;
                    tbl_op.row   = ROW_MAX_W'(r_hash[HASH_BITS-1:ROW_LSB_W]);
                    tbl_op.data  = tbl_word | bit_mask;
                    n_hit        = 1'b1;
                end
            end
            default: begin
                n_hit = cur_bit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= s_axis_tuser;
            r_hash <= hash_now;
        end
        if (done) begin
            r_out_index <= OUT_IDX_W'(r_hash);
            r_out_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fill_all  <= 1'b0;
            r_bcast_en  <= 1'b1;
        end else begin
            if (accept) begin
                r_state <= ST_EXEC;
            end else if (done) begin
                r_state <= ST_IDLE;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FILL_ALL: r_fill_all <= i_cfg_data;
                    CFG_BCAST_EN: r_bcast_en <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_hit, r_out_index});

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC) && !m_axis_tvalid || (r_state == ST_EXEC))
        else $error("Accepted item did not enter the execute state.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && (r_cmd == CMD_ADD) && !r_fill_all) |=> (m_axis_tvalid && m_axis_tdata[OUT_IDX_W]))
        else $error("Added address does not report its table bit as set.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && (r_cmd == CMD_REBUILD) && r_fill_all) |=> m_axis_tdata[OUT_IDX_W])
        else $error("Fill-all rebuild reported a clear table bit.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (m_axis_tdata[OUT_IDX_W-1:0] == $past(OUT_IDX_W'(r_hash))))
        else $error("Reported hash index differs from the item's hash.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_op.wr_en || tbl_op.clear_all) |-> done)
        else $error("Table modified outside the write-back cycle.");

endmodule

`default_nettype wire

FILE: tb/sv/multicast_hash_filter_tb.sv
// Self-checking testbench for the multicast hash filter: directed table, then random traffic.
`timescale 1ns / 1ps

module multicast_hash_filter_tb;
    import mhf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam logic [31:0]      ETH_CRC_POLY = 32'hEDB88320;
    localparam logic [MAC_W-1:0] ALL_ONES_MAC = 48'hFFFF_FFFF_FFFF;
    localparam int FILTER_BITS     = 1 << HASH_BITS_DEF;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_ITEMS     = 100;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int POOL_DEPTH      = 32;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CMD_W-1:0]     cmd;
        logic [MAC_W-1:0]     mac;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 reg_val;
        logic                 hit_known;
        logic                 hit_val;
    } stim_row_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] hash_index;
        logic                 hit;
    } lookup_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [MAC_W-1:0]        s_axis_tdata = '0;     // [47:0] mac
    logic [CMD_W-1:0]        s_axis_tuser = '0;     // [1:0] cmd
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;          // [8:0] hash_index, [9] hit
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic                    i_cfg_data = 1'b0;

    logic [FILTER_BITS-1:0]  filter_bits;
    logic                    fill_all_mode;
    logic                    bcast_on;
    lookup_result_t          pending_lookups[$];
    logic [MAC_W-1:0]        mac_pool[$];
    stim_row_t               directed_rows[];

    int source_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int rebuilds_sent = 0;
    int reg_writes = 0;

    multicast_hash_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [HASH_BITS_DEF-1:0] mac_bucket(input logic [MAC_W-1:0] mac);
        logic [31:0] crc;
        crc = '1;
        for (int i = 0; i < MAC_W; i++) begin
            if (crc[0] ^ mac[i]) begin
                crc = (crc >> 1) ^ ETH_CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc[HASH_BITS_DEF-1:0];
    endfunction

    // Applies one command to the model table and returns the lookup it reports.
    function automatic lookup_result_t filter_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [MAC_W-1:0] mac);
        lookup_result_t res;
        logic [HASH_BITS_DEF-1:0] bucket;
        bucket = mac_bucket(mac);
        if (cmd == CMD_REBUILD) begin
            if (fill_all_mode) begin
                filter_bits = '1;
            end else begin
                filter_bits = '0;
                if (bcast_on) begin
                    filter_bits[mac_bucket(ALL_ONES_MAC)] = 1'b1;
                end
            end
        end else if (cmd == CMD_ADD && !fill_all_mode) begin
            filter_bits[bucket] = 1'b1;
        end
        res.hash_index = bucket;
        res.hit        = filter_bits[bucket];
        return res;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [MAC_W-1:0] mac,
                             input logic hit_known, input logic hit_val);
        lookup_result_t res;
        while ($urandom_range(0, 99) < source_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mac;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        res = filter_command(cmd, mac);
        if (hit_known) begin
            res.hit = hit_val;
        end
        pending_lookups.push_back(res);
        items_sent++;
        if (cmd == CMD_REBUILD) begin
            rebuilds_sent++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FILL_ALL) begin
            fill_all_mode = val;
        end else begin
            bcast_on = val;
        end
        reg_writes++;
    endtask

    function automatic logic [MAC_W-1:0] pick_mac();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55 && mac_pool.size() != 0) begin
            return mac_pool[$urandom_range(0, mac_pool.size() - 1)];
        end else if (sel < 58) begin
            return ALL_ONES_MAC;
        end else if (sel < 60) begin
            return '0;
        end
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            return CMD_REBUILD;
        end else if (sel < 45) begin
            return CMD_ADD;
        end else if (sel < 90) begin
            return CMD_TEST;
        end
        return CMD_UNUSED;
    endfunction

    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        lookup_result_t exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tdata[OUT_IDX_W]) begin
                hits_seen++;
            end
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with nothing expected, got tdata %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                exp_res = pending_lookups.pop_front();
                if (m_axis_tdata[OUT_IDX_W-1:0] !== exp_res.hash_index) begin
                    $display("%0t: hash_index mismatch, expected %0d, got %0d", $time,
                             exp_res.hash_index, m_axis_tdata[OUT_IDX_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_IDX_W] !== exp_res.hit) begin
                    $display("%0t: hit mismatch, expected %0b, got %0b", $time,
                             exp_res.hit, m_axis_tdata[OUT_IDX_W]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_IDX_W+1] !== '0) begin
                    $display("%0t: pad bits mismatch, expected 0, got %h", $time,
                             m_axis_tdata[OUT_TDATA_W-1:OUT_IDX_W+1]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [MAC_W-1:0] mac;
        filter_bits   = '0;
        fill_all_mode = 1'b0;
        bcast_on      = 1'b1;
        directed_rows = '{
            '{ROW_ITEM, CMD_TEST,    48'h0000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b1, 1'b0},
            '{ROW_ITEM, CMD_TEST,    48'hFFFF_FFFF_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b0},
            '{ROW_ITEM, CMD_UNUSED,  48'h1234_5678_9ABC, CFG_FILL_ALL, 1'b0, 1'b1, 1'b0},
            '{ROW_ITEM, CMD_ADD,     48'h0000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_ADD,     48'hFFFF_FFFF_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_TEST,    48'h0000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_ADD,     48'h0100_005E_0001, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_REBUILD, 48'h0000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_TEST,    48'hFFFF_FFFF_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_TEST,    48'h0100_005E_0001, CFG_FILL_ALL, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_TEST,    48'h0000_0000_0000, CFG_BCAST_EN, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_REBUILD, 48'hFFFF_FFFF_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b0},
            '{ROW_ITEM, CMD_TEST,    48'hFFFF_FFFF_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b0},
            '{ROW_CFG,  CMD_TEST,    48'h0000_0000_0000, CFG_FILL_ALL, 1'b1, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_REBUILD, 48'h5555_5555_5555, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_TEST,    48'h1234_5678_9ABC, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_ADD,     48'hAAAA_AAAA_AAAA, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_UNUSED,  48'hFFFF_0000_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_CFG,  CMD_TEST,    48'h0000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_ADD,     48'h8000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_ITEM, CMD_REBUILD, 48'h0000_FFFF_0000, CFG_FILL_ALL, 1'b0, 1'b1, 1'b0},
            '{ROW_ITEM, CMD_ADD,     48'h8000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1},
            '{ROW_CFG,  CMD_TEST,    48'h0000_0000_0000, CFG_FILL_ALL, 1'b1, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_ADD,     48'h0000_0000_0001, CFG_FILL_ALL, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_TEST,    48'h0000_0000_0000, CFG_FILL_ALL, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_TEST,    48'h0000_0000_0000, CFG_BCAST_EN, 1'b1, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_REBUILD, 48'h0123_4567_89AB, CFG_FILL_ALL, 1'b0, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_TEST,    48'hFFFF_FFFF_FFFF, CFG_FILL_ALL, 1'b0, 1'b1, 1'b1}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                send_item(directed_rows[r].cmd, directed_rows[r].mac,
                          directed_rows[r].hit_known, directed_rows[r].hit_val);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_reg(CFG_FILL_ALL, (p == 3 || p == 6));
            write_reg(CFG_BCAST_EN, (p % 3 != 1));
            source_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 70 : 8) : 0;
            sink_stall_pct  = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 70 : 8) : 0;
            if (p == 0) begin
                // The sink holds off long enough for the filter to back up its input.
                hold_reqs <= hold_reqs + 1;
            end
            send_item(CMD_REBUILD, pick_mac(), 1'b0, 1'b0);
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                cmd = pick_cmd();
                mac = pick_mac();
                if (cmd == CMD_ADD) begin
                    mac_pool.push_back(mac);
                    if (mac_pool.size() > POOL_DEPTH) begin
                        void'(mac_pool.pop_front());
                    end
                end
                send_item(cmd, mac, 1'b0, 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d rebuilds) and made %0d register writes.",
                 items_sent, rebuilds_sent, reg_writes);
        $display("Checked %0d lookups, %0d of them hits, across %0d traffic phases.",
                 results_seen, hits_seen, PHASE_COUNT);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
